// ===== rtl/assert_macros.svh =====
// assertion macros shared by the cipher rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// clocked property, disabled while reset is asserted
`define WCU_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked property, checked during reset as well
`define WCU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WCU_ASSERT(lbl, clk, rstn, prop, msg)
`define WCU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/wcu_pkg.sv =====
// types, tables and helper functions for the warp-style cipher unit
// no dependencies; imported by wcu_stage and warp_cipher_enc_dec_unit
package wcu_pkg;

	localparam int NIBS         = 32;
	localparam int HALF_NIBS    = 16;
	localparam int RND_W        = 6;
	localparam int CONST_ROUNDS = 41;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_KEY_HALF_ZERO = 2'd0,
		CFG_KEY_HALF_ONE  = 2'd1,
		CFG_ROUNDS        = 2'd2
	} cfg_idx_t;

	// request payload
	typedef struct packed {
		logic        operation;
		logic [63:0] block_in_low;
		logic [63:0] block_in_high;
	} in_data_t;

	// result payload
	typedef struct packed {
		logic [63:0] block_out_low;
		logic [63:0] block_out_high;
	} out_data_t;

	// item traveling down the pipeline
	typedef struct packed {
		logic         op;
		logic [127:0] block;
	} wcu_item_t;

	// shared controls fanned out to every stage
	typedef struct packed {
		logic             adv;
		logic [RND_W-1:0] nr;
		logic [63:0]      key_one;
		logic [63:0]      key_zero;
	} wcu_ctrl_t;

	localparam logic [3:0] SBOX [0:15] = '{
		4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
		4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
	};

	localparam logic [4:0] NIB_PERM [0:NIBS-1] = '{
		5'd31, 5'd6,  5'd29, 5'd14, 5'd1,  5'd12, 5'd21, 5'd8,
		5'd27, 5'd2,  5'd3,  5'd0,  5'd25, 5'd4,  5'd23, 5'd10,
		5'd15, 5'd22, 5'd13, 5'd30, 5'd17, 5'd28, 5'd5,  5'd24,
		5'd11, 5'd18, 5'd19, 5'd16, 5'd9,  5'd20, 5'd7,  5'd26
	};

	localparam logic [3:0] RC_A [0:CONST_ROUNDS-1] = '{
		4'h0, 4'h0, 4'h1, 4'h3, 4'h7, 4'hf, 4'hf, 4'hf, 4'he, 4'hd,
		4'ha, 4'h5, 4'ha, 4'h5, 4'hb, 4'h6, 4'hc, 4'h9, 4'h3, 4'h6,
		4'hd, 4'hb, 4'h7, 4'he, 4'hd, 4'hb, 4'h6, 4'hd, 4'ha, 4'h4,
		4'h9, 4'h2, 4'h4, 4'h9, 4'h3, 4'h7, 4'he, 4'hc, 4'h8, 4'h1, 4'h2
	};

	localparam logic [3:0] RC_B [0:CONST_ROUNDS-1] = '{
		4'h4, 4'hc, 4'hc, 4'hc, 4'hc, 4'hc, 4'h8, 4'h4, 4'h8, 4'h4,
		4'h8, 4'h4, 4'hc, 4'h8, 4'h0, 4'h4, 4'hc, 4'h8, 4'h4, 4'hc,
		4'hc, 4'h8, 4'h4, 4'hc, 4'h8, 4'h4, 4'h8, 4'h0, 4'h4, 4'h8,
		4'h0, 4'h4, 4'hc, 4'hc, 4'h8, 4'h0, 4'h0, 4'h4, 4'h8, 4'h4, 4'hc
	};

	function automatic logic [3:0] wcu_sbox(input logic [3:0] x);
		return SBOX[x];
	endfunction

	// round constants, last entry repeats past the end of the table
	function automatic logic [3:0] wcu_rc_a(input logic [RND_W-1:0] idx);
		logic [3:0] v;
		if (idx < RND_W'(CONST_ROUNDS)) begin
			v = RC_A[idx];
		end else begin
			v = RC_A[CONST_ROUNDS-1];
		end
		return v;
	endfunction

	function automatic logic [3:0] wcu_rc_b(input logic [RND_W-1:0] idx);
		logic [3:0] v;
		if (idx < RND_W'(CONST_ROUNDS)) begin
			v = RC_B[idx];
		end else begin
			v = RC_B[CONST_ROUNDS-1];
		end
		return v;
	endfunction

endpackage

// ===== rtl/wcu_stage.sv =====
// one pipeline stage of the cipher unit: a single encrypt or decrypt round, or a pass-through for stages
// past the round count; depends on wcu_pkg
module wcu_stage
	import wcu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  wcu_ctrl_t        ctrl,
	input  logic [RND_W-1:0] stage_num,
	input  logic             vld_in,
	input  wcu_item_t        item_in,
	output logic             vld_out,
	output wcu_item_t        item_out
);

	logic             vld_s1;
	wcu_item_t        item_s1;
	wcu_item_t        item_nxt;
	logic             active;
	logic [RND_W-1:0] idx;
	logic [63:0]      kh;
	logic [3:0]       rca;
	logic [3:0]       rcb;
	logic [3:0]       cur   [NIBS];
	logic [3:0]       mixe  [NIBS];
	logic [3:0]       enc   [NIBS];
	logic [3:0]       dperm [NIBS];
	logic [3:0]       dec   [NIBS];
	logic [3:0]       res   [NIBS];

	// round selection: decrypt walks the rounds from the top down
	assign active = (stage_num < ctrl.nr);
	assign idx    = item_in.op ? (ctrl.nr - RND_W'(1) - stage_num) : stage_num;
	assign kh     = idx[0] ? ctrl.key_one : ctrl.key_zero;
	assign rca    = wcu_rc_a(idx);
	assign rcb    = wcu_rc_b(idx);

	// round datapath, both directions side by side
	always_comb begin
		for (int i = 0; i < NIBS; i++) begin
			cur[i] = item_in.block[4*i +: 4];
		end

		// encrypt: mix, constants, forward permutation
		for (int i = 0; i < NIBS; i++) begin
			mixe[i] = cur[i];
		end
		for (int i = 0; i < HALF_NIBS; i++) begin
			mixe[2*i+1] = cur[2*i+1] ^ wcu_sbox(cur[2*i]) ^ kh[4*i +: 4];
		end
		mixe[1] = mixe[1] ^ rca;
		mixe[3] = mixe[3] ^ rcb;
		for (int i = 0; i < NIBS; i++) begin
			enc[NIB_PERM[i]] = mixe[i];
		end

		// decrypt: inverse permutation, constants, mix
		for (int i = 0; i < NIBS; i++) begin
			dperm[i] = cur[NIB_PERM[i]];
		end
		dperm[1] = dperm[1] ^ rca;
		dperm[3] = dperm[3] ^ rcb;
		for (int i = 0; i < NIBS; i++) begin
			dec[i] = dperm[i];
		end
		for (int i = 0; i < HALF_NIBS; i++) begin
			dec[2*i+1] = dperm[2*i+1] ^ wcu_sbox(dperm[2*i]) ^ kh[4*i +: 4];
		end

		// stages past the round count pass the block through
		for (int i = 0; i < NIBS; i++) begin
			if (!active) begin
				res[i] = cur[i];
			end else if (item_in.op) begin
				res[i] = dec[i];
			end else begin
				res[i] = enc[i];
			end
		end

		item_nxt.op = item_in.op;
		for (int i = 0; i < NIBS; i++) begin
			item_nxt.block[4*i +: 4] = res[i];
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ctrl.adv) begin
			vld_s1 <= vld_in;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (ctrl.adv && vld_in) begin
			item_s1 <= item_nxt;
		end
	end

	assign vld_out  = vld_s1;
	assign item_out = item_s1;

endmodule

// ===== rtl/warp_cipher_enc_dec_unit.sv =====
// top level of the warp-style 128-bit cipher unit, fully unrolled pipeline
// depends on wcu_pkg, wcu_stage and assert_macros.svh
//
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | in_data (in_data_t)
// out     | output    | out_valid/out_stall | out_data (out_data_t)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one block per cycle while out_stall does not halt the pipeline; one round
// per stage, and the last stage register drives the result.
// stages beyond the configured round count pass the block unchanged.
// the whole pipeline advances together; it halts only while a result
// sits in the last stage and out_stall is high.
// reset empties the pipeline and loads keys 0 and rounds MAX_ROUNDS.
`include "assert_macros.svh"
module warp_cipher_enc_dec_unit
	import wcu_pkg::*;
#(
	parameter int MAX_ROUNDS = 41
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_data_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_data_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0]       key_zero_q;
	logic [63:0]       key_one_q;
	logic [RND_W-1:0]  rounds_q;
	logic [RND_W-1:0]  nr_sat;
	logic              adv;
	wcu_ctrl_t         ctrl;
	logic [MAX_ROUNDS:0] vld_chain;
	wcu_item_t         item_chain [MAX_ROUNDS+1];
	logic [MAX_ROUNDS-1:0] pipe_vld;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_zero_q <= '0;
			key_one_q  <= '0;
			rounds_q   <= RND_W'(MAX_ROUNDS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEY_HALF_ZERO: key_zero_q <= cfg_data;
				CFG_KEY_HALF_ONE:  key_one_q  <= cfg_data;
				CFG_ROUNDS:        rounds_q   <= cfg_data[RND_W-1:0];
				default: ;
			endcase
		end
	end

	// round count saturates at the pipeline depth
	assign nr_sat = (rounds_q > RND_W'(MAX_ROUNDS)) ? RND_W'(MAX_ROUNDS) : rounds_q;

	// global advance: hold everything while the result is refused
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign ctrl.adv      = adv;
	assign ctrl.nr       = nr_sat;
	assign ctrl.key_one  = key_one_q;
	assign ctrl.key_zero = key_zero_q;

	// pipeline entry
	assign vld_chain[0]        = in_valid;
	assign item_chain[0].op    = in_data.operation;
	assign item_chain[0].block = {in_data.block_in_high, in_data.block_in_low};

	// one round per stage
	for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_stage
		wcu_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.stage_num (RND_W'(k)),
			.vld_in    (vld_chain[k]),
			.item_in   (item_chain[k]),
			.vld_out   (vld_chain[k+1]),
			.item_out  (item_chain[k+1])
		);
	end

	assign pipe_vld = vld_chain[MAX_ROUNDS:1];

	// result from the last stage register
	assign out_valid               = vld_chain[MAX_ROUNDS];
	assign out_data.block_out_low  = item_chain[MAX_ROUNDS].block[63:0];
	assign out_data.block_out_high = item_chain[MAX_ROUNDS].block[127:64];

	// checks
	`WCU_ASSERT(a_accept_enters, clk, arst_n, (in_valid && !in_stall) |=> vld_chain[1], "accepted request did not enter stage one")
	`WCU_ASSERT(a_hold_on_stall, clk, arst_n, (out_valid && out_stall) |=> $stable(pipe_vld), "pipeline valids moved while the result was refused")
	`WCU_ASSERT(a_taken_result_drains, clk, arst_n, (out_valid && !out_stall && !vld_chain[MAX_ROUNDS-1]) |=> !out_valid, "taken result repeated on the output")
	`WCU_ASSERT_ALWAYS(a_round_bound, clk, (!arst_n || (nr_sat <= RND_W'(MAX_ROUNDS))), "round count exceeds the pipeline depth")

endmodule
